@@ design/ecsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared codes and types for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;

   // serial unit operations
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_MODULUS = 2'd0;
   localparam logic [1:0] CSR_CURVE_A = 2'd1;

   typedef struct packed {
      logic start;
      logic op;
   } ecsm_cmd_type;

   typedef struct packed {
      logic done;
   } ecsm_sts_type;

endpackage

@@ design/ecsm_serial_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsm_serial_unit
// Bit-serial modular multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module ecsm_serial_unit #(
   parameter int FIELD_BITS = 63
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ecsm_pkg::ecsm_cmd_type   cmd,
   input  logic [FIELD_BITS-1:0]    opa,
   input  logic [FIELD_BITS-1:0]    opb,
   input  logic [FIELD_BITS-1:0]    modulus,
   output ecsm_pkg::ecsm_sts_type   sts,
   output logic [FIELD_BITS-1:0]    res,
   output logic [FIELD_BITS-1:0]    quo
);

   localparam int W  = FIELD_BITS;
   localparam int CW = $clog2(W);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic          op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  aa_ff, aa_in;
   logic [W-1:0]  bb_ff, bb_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W:0]    trial;

   function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] q);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, q}) s = s - {1'b0, q};
      return s[W-1:0];
   endfunction

   // mul: acc sum, aa doubling multiplicand, bb multiplier shifted right
   // div: acc partial remainder, bb dividend / quotient shift, q divisor
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      aa_in   = aa_ff;
      bb_in   = bb_ff;
      q_in    = q_ff;
      trial   = {acc_ff, bb_ff[W-1]};
      if (cmd.start) begin
         run_in = 1'b1;
         op_in  = cmd.op;
         cnt_in = '0;
         acc_in = '0;
         if (cmd.op == ecsm_pkg::OP_MUL) begin
            aa_in = opa;
            bb_in = opb;
            q_in  = modulus;
         end else begin
            aa_in = '0;
            bb_in = opa;
            q_in  = opb;
         end
      end else if (run_ff) begin
         if (op_ff == ecsm_pkg::OP_MUL) begin
            if (bb_ff[0]) acc_in = madd(acc_ff, aa_ff, q_ff);
            aa_in = madd(aa_ff, aa_ff, q_ff);
            bb_in = bb_ff >> 1;
         end else begin
            if (trial >= {1'b0, q_ff}) begin
               acc_in = trial[W-1:0] - q_ff;
               bb_in  = {bb_ff[W-2:0], 1'b1};
            end else begin
               acc_in = trial[W-1:0];
               bb_in  = {bb_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      aa_ff  <= aa_in;
      bb_ff  <= bb_in;
      q_ff   <= q_in;
   end

   assign sts.done = done_ff;
   assign res      = acc_ff;
   assign quo      = bb_ff;

endmodule

@@ design/ec_scalar_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ec_scalar_multiply
// Affine k*P on y^2 = x^3 + a*x + b mod q by right-to-left double-and-add.
// ----------------------------------------------------------------------------
// Usage:
//   csr channel (csr_valid/csr_ready, always ready) writes modulus (index 0)
//   and curve_a (index 1); write only while busy is low.
//   A request is taken when start is high and busy is low. busy stays high
//   until the result is shown; rsp_valid then marks result_x/y/at_infinity
//   for exactly one cycle. The receiver cannot stall.
//   A request runs three reductions (curve_a, x and y), then for every
//   scanned scalar bit up to two point operations. A point operation costs
//   three (add) to five (double) multiplies plus a divide and a multiply
//   per Euclid step of the inversion. All of it runs through one
//   bit-serial multiply/divide unit, one bit per cycle. A modulus below 3
//   skips all of it and answers with the point at infinity.
//   One request at a time.
//   Reset (synchronous) sets modulus to 3, curve_a to 0 and returns to idle.
// ----------------------------------------------------------------------------
module ec_scalar_multiply #(
   parameter int SCALAR_BITS = 64,
   parameter int FIELD_BITS  = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [SCALAR_BITS-1:0] req_scalar,
   input  logic [FIELD_BITS-1:0]  req_point_x,
   input  logic [FIELD_BITS-1:0]  req_point_y,
   input  logic                   req_point_at_infinity,
   output logic                   rsp_valid,
   output logic [FIELD_BITS-1:0]  rsp_result_x,
   output logic [FIELD_BITS-1:0]  rsp_result_y,
   output logic                   rsp_result_at_infinity,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [FIELD_BITS-1:0]  csr_wdata
);

   localparam int W  = FIELD_BITS;
   localparam int S  = SCALAR_BITS;
   localparam int KW = $clog2(S + 1);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_WAIT  = 5'd1;
   localparam logic [4:0] ST_RA    = 5'd2;
   localparam logic [4:0] ST_RX    = 5'd3;
   localparam logic [4:0] ST_RY    = 5'd4;
   localparam logic [4:0] ST_LOOP  = 5'd5;
   localparam logic [4:0] ST_DBL   = 5'd6;
   localparam logic [4:0] ST_SHIFT = 5'd7;
   localparam logic [4:0] ST_ADD0  = 5'd8;
   localparam logic [4:0] ST_D1    = 5'd9;
   localparam logic [4:0] ST_D2    = 5'd10;
   localparam logic [4:0] ST_INV1  = 5'd11;
   localparam logic [4:0] ST_INV2  = 5'd12;
   localparam logic [4:0] ST_INV3  = 5'd13;
   localparam logic [4:0] ST_L0    = 5'd14;
   localparam logic [4:0] ST_L1    = 5'd15;
   localparam logic [4:0] ST_L2    = 5'd16;
   localparam logic [4:0] ST_L3    = 5'd17;
   localparam logic [4:0] ST_L4    = 5'd18;
   localparam logic [4:0] ST_L5    = 5'd19;
   localparam logic [4:0] ST_FIN   = 5'd20;
   localparam logic [4:0] ST_DONE  = 5'd21;

   logic [4:0]    state_ff, state_in;
   logic [4:0]    ret_ff, ret_in;
   logic [4:0]    add_ret_ff, add_ret_in;
   logic          dest_dbl_ff, dest_dbl_in;
   logic [S-1:0]  k_ff, k_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  modulus_ff, modulus_in;
   logic [W-1:0]  curve_a_ff, curve_a_in;
   logic [W-1:0]  amod_ff, amod_in;
   logic [W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic          dinf_ff, dinf_in;
   logic [W-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic          rinf_ff, rinf_in;
   logic [W-1:0]  px_ff, px_in, py_ff, py_in, sx_ff, sx_in, sy_ff, sy_in;
   logic          pinf_ff, pinf_in, sinf_ff, sinf_in;
   logic [W-1:0]  x3_ff, x3_in, y3_ff, y3_in;
   logic          inf3_ff, inf3_in;
   logic [W-1:0]  num_ff, num_in, lam_ff, lam_in, tmp_ff, tmp_in;
   logic [W-1:0]  r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic          rsp_inf_ff, rsp_inf_in;

   ecsm_pkg::ecsm_cmd_type cmd;
   ecsm_pkg::ecsm_sts_type sts;
   logic [W-1:0]  opa, opb, unit_res, unit_quo;
   logic [W-1:0]  three, qt_red;

   function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] q);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, q}) s = s - {1'b0, q};
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] q);
      logic [W-1:0] r;
      if (x >= y) r = x - y;
      else        r = x + (q - y);
      return r;
   endfunction

   ecsm_serial_unit #(.FIELD_BITS(W)) u_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .opa     (opa),
      .opb     (opb),
      .modulus (modulus_ff),
      .sts     (sts),
      .res     (unit_res),
      .quo     (unit_quo)
   );

   // 3 mod q, with q at least 3
   assign three  = (modulus_ff == W'(3)) ? '0 : W'(3);
   assign qt_red = (unit_quo >= modulus_ff) ? unit_quo - modulus_ff : unit_quo;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      add_ret_in   = add_ret_ff;
      dest_dbl_in  = dest_dbl_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      modulus_in   = modulus_ff;
      curve_a_in   = curve_a_ff;
      amod_in      = amod_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dinf_in      = dinf_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rinf_in      = rinf_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pinf_in      = pinf_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sinf_in      = sinf_ff;
      x3_in        = x3_ff;
      y3_in        = y3_ff;
      inf3_in      = inf3_ff;
      num_in       = num_ff;
      lam_in       = lam_ff;
      tmp_in       = tmp_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      rsp_valid_in = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_inf_in   = rsp_inf_ff;
      cmd.start    = 1'b0;
      cmd.op       = ecsm_pkg::OP_MUL;
      opa          = '0;
      opb          = '0;

      if (csr_valid) begin
         case (csr_index)
            ecsm_pkg::CSR_MODULUS: modulus_in = csr_wdata;
            ecsm_pkg::CSR_CURVE_A: curve_a_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               k_in    = req_scalar;
               cnt_in  = '0;
               dx_in   = req_point_x;
               dy_in   = req_point_y;
               dinf_in = req_point_at_infinity;
               rx_in   = '0;
               ry_in   = '0;
               rinf_in = 1'b1;
               if (modulus_ff < W'(3)) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.start = 1'b1;
                  cmd.op    = ecsm_pkg::OP_DIV;
                  opa       = curve_a_ff;
                  opb       = modulus_ff;
                  ret_in    = ST_RA;
                  state_in  = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (sts.done) state_in = ret_ff;
         end
         ST_RA: begin
            amod_in   = unit_res;
            cmd.start = 1'b1;
            cmd.op    = ecsm_pkg::OP_DIV;
            opa       = dx_ff;
            opb       = modulus_ff;
            ret_in    = ST_RX;
            state_in  = ST_WAIT;
         end
         ST_RX: begin
            dx_in     = dinf_ff ? '0 : unit_res;
            cmd.start = 1'b1;
            cmd.op    = ecsm_pkg::OP_DIV;
            opa       = dy_ff;
            opb       = modulus_ff;
            ret_in    = ST_RY;
            state_in  = ST_WAIT;
         end
         ST_RY: begin
            dy_in    = dinf_ff ? '0 : unit_res;
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (cnt_ff == KW'(S) || k_ff == '0) begin
               state_in = ST_DONE;
            end else if (k_ff[0]) begin
               px_in       = rx_ff;
               py_in       = ry_ff;
               pinf_in     = rinf_ff;
               sx_in       = dx_ff;
               sy_in       = dy_ff;
               sinf_in     = dinf_ff;
               dest_dbl_in = 1'b0;
               add_ret_in  = ST_DBL;
               state_in    = ST_ADD0;
            end else begin
               state_in = ST_DBL;
            end
         end
         ST_DBL: begin
            // the last doubling cannot reach the result
            if (k_ff[S-1:1] == '0) begin
               state_in = ST_SHIFT;
            end else begin
               px_in       = dx_ff;
               py_in       = dy_ff;
               pinf_in     = dinf_ff;
               sx_in       = dx_ff;
               sy_in       = dy_ff;
               sinf_in     = dinf_ff;
               dest_dbl_in = 1'b1;
               add_ret_in  = ST_SHIFT;
               state_in    = ST_ADD0;
            end
         end
         ST_SHIFT: begin
            k_in     = k_ff >> 1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_LOOP;
         end
         ST_ADD0: begin
            if (pinf_ff) begin
               x3_in    = sx_ff;
               y3_in    = sy_ff;
               inf3_in  = sinf_ff;
               state_in = ST_FIN;
            end else if (sinf_ff) begin
               x3_in    = px_ff;
               y3_in    = py_ff;
               inf3_in  = 1'b0;
               state_in = ST_FIN;
            end else if (px_ff == sx_ff) begin
               if (madd(py_ff, sy_ff, modulus_ff) == '0 || py_ff != sy_ff || py_ff == '0) begin
                  x3_in    = '0;
                  y3_in    = '0;
                  inf3_in  = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  cmd.start = 1'b1;
                  opa       = px_ff;
                  opb       = px_ff;
                  ret_in    = ST_D1;
                  state_in  = ST_WAIT;
               end
            end else begin
               num_in   = msub(sy_ff, py_ff, modulus_ff);
               r1_in    = msub(sx_ff, px_ff, modulus_ff);
               r0_in    = modulus_ff;
               t0_in    = '0;
               t1_in    = W'(1);
               state_in = ST_INV1;
            end
         end
         ST_D1: begin
            cmd.start = 1'b1;
            opa       = three;
            opb       = unit_res;
            ret_in    = ST_D2;
            state_in  = ST_WAIT;
         end
         ST_D2: begin
            num_in   = madd(unit_res, amod_ff, modulus_ff);
            r1_in    = madd(py_ff, py_ff, modulus_ff);
            r0_in    = modulus_ff;
            t0_in    = '0;
            t1_in    = W'(1);
            state_in = ST_INV1;
         end
         ST_INV1: begin
            if (r1_ff == '0) begin
               if (r0_ff != W'(1)) begin
                  x3_in    = '0;
                  y3_in    = '0;
                  inf3_in  = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_L0;
               end
            end else begin
               cmd.start = 1'b1;
               cmd.op    = ecsm_pkg::OP_DIV;
               opa       = r0_ff;
               opb       = r1_ff;
               ret_in    = ST_INV2;
               state_in  = ST_WAIT;
            end
         end
         ST_INV2: begin
            r0_in     = r1_ff;
            r1_in     = unit_res;
            cmd.start = 1'b1;
            opa       = qt_red;
            opb       = t1_ff;
            ret_in    = ST_INV3;
            state_in  = ST_WAIT;
         end
         ST_INV3: begin
            t0_in    = t1_ff;
            t1_in    = msub(t0_ff, unit_res, modulus_ff);
            state_in = ST_INV1;
         end
         ST_L0: begin
            cmd.start = 1'b1;
            opa       = num_ff;
            opb       = t0_ff;
            ret_in    = ST_L1;
            state_in  = ST_WAIT;
         end
         ST_L1: begin
            lam_in    = unit_res;
            cmd.start = 1'b1;
            opa       = unit_res;
            opb       = unit_res;
            ret_in    = ST_L2;
            state_in  = ST_WAIT;
         end
         ST_L2: begin
            tmp_in   = msub(unit_res, px_ff, modulus_ff);
            state_in = ST_L3;
         end
         ST_L3: begin
            x3_in    = msub(tmp_ff, sx_ff, modulus_ff);
            state_in = ST_L4;
         end
         ST_L4: begin
            cmd.start = 1'b1;
            opa       = lam_ff;
            opb       = msub(px_ff, x3_ff, modulus_ff);
            ret_in    = ST_L5;
            state_in  = ST_WAIT;
         end
         ST_L5: begin
            y3_in    = msub(unit_res, py_ff, modulus_ff);
            inf3_in  = 1'b0;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (dest_dbl_ff) begin
               dx_in   = x3_ff;
               dy_in   = y3_ff;
               dinf_in = inf3_ff;
            end else begin
               rx_in   = x3_ff;
               ry_in   = y3_ff;
               rinf_in = inf3_ff;
            end
            state_in = add_ret_ff;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = rinf_ff ? '0 : rx_ff;
            rsp_y_in     = rinf_ff ? '0 : ry_ff;
            rsp_inf_in   = rinf_ff;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= W'(3);
         curve_a_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
         curve_a_ff   <= curve_a_in;
      end
      ret_ff      <= ret_in;
      add_ret_ff  <= add_ret_in;
      dest_dbl_ff <= dest_dbl_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      amod_ff     <= amod_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dinf_ff     <= dinf_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rinf_ff     <= rinf_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pinf_ff     <= pinf_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sinf_ff     <= sinf_in;
      x3_ff       <= x3_in;
      y3_ff       <= y3_in;
      inf3_ff     <= inf3_in;
      num_ff      <= num_in;
      lam_ff      <= lam_in;
      tmp_ff      <= tmp_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_inf_ff  <= rsp_inf_in;
   end

   assign busy                   = (state_ff != ST_IDLE);
   assign csr_ready              = 1'b1;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_x           = rsp_x_ff;
   assign rsp_result_y           = rsp_y_ff;
   assign rsp_result_at_infinity = rsp_inf_ff;

endmodule
